FILE: hdl/nbli_pkg.sv
// nbli_pkg: shared types and constants for the nearest-bracket interpolator.
// No dependencies; used by nbli_fifo, nbli_engine and the top level.
`default_nettype none
package nbli_pkg;
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_SPAN = 2'd2;

	localparam logic [1:0] REG_TABLE_LENGTH = 2'd0;

	// one classified beat handed from front to back
	typedef struct packed {
		logic        func;
		logic [7:0]  entry_index;
		logic [31:0] x_value;
		logic [31:0] y_value;
	} item_t;
endpackage
`default_nettype wire

FILE: hdl/nbli_fifo.sv
// nbli_fifo: two-entry queue between the front (input) and the back (engine).
// Depends on nbli_pkg.
`default_nettype none
module nbli_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire nbli_pkg::item_t in_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output nbli_pkg::item_t      out_item
);
	nbli_pkg::item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_item;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (out_valid && out_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
		end
	end
endmodule
`default_nettype wire

FILE: hdl/nbli_div.sv
// nbli_div: unsigned restoring divider, one quotient bit per cycle.
// 64-bit dividend over 33-bit divisor; no dependencies.
`default_nettype none
module nbli_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [32:0] divisor,
	output logic             done,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;
	logic [34:0] diff;

	assign trial    = {rem_q[32:0], quo_q[63]};
	assign diff     = {1'b0, trial} - {2'b0, dvs_q};
	assign quotient = quo_q;

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0; cnt_q <= '0;
			quo_q <= '0; rem_q <= '0; dvs_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; cnt_q <= 7'd64;
				quo_q <= dividend; rem_q <= '0; dvs_q <= divisor;
			end else if (busy_q) begin
				if (diff[34]) begin
					rem_q <= trial; quo_q <= {quo_q[62:0], 1'b0};
				end else begin
					rem_q <= diff[33:0]; quo_q <= {quo_q[62:0], 1'b1};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/nbli_engine.sv
// nbli_engine: table memories, nearest-entry scan, bracket fetch and interpolation.
// Depends on nbli_pkg and nbli_div.
`default_nettype none
module nbli_engine #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [8:0]      table_length,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire nbli_pkg::item_t item,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output logic [31:0]          res_value,
	output logic [1:0]           res_status
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = AW + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_NEAR  = 4'd2;
	localparam logic [3:0] S_RDLO  = 4'd3;
	localparam logic [3:0] S_RDHI  = 4'd4;
	localparam logic [3:0] S_CALC  = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_SUM   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;
	localparam logic [3:0] S_LAST  = 4'd10;
	localparam logic [3:0] S_WAIT  = 4'd11;

	logic [31:0] x_mem [TABLE_DEPTH];
	logic [31:0] y_mem [TABLE_DEPTH];
	logic [31:0] xrd_q, yrd_q;
	logic [AW-1:0] raddr;

	logic [3:0]    state_q;
	logic [CW-1:0] n_q, idx_q;
	logic [AW-1:0] near_q, hi_q;
	logic          rd_v_q, first_q;
	logic [AW-1:0] rd_i_q;
	logic [32:0]   best_q;
	logic signed [31:0] xq_q, xl_q, yl_q;
	logic signed [32:0] dx_q, dy_q, dq_q;
	logic [31:0]   mdy_q, mdq_q;
	logic [32:0]   mdx_q;
	logic [63:0]   prod_q;
	logic          neg_q;
	logic          div_start, div_done;
	logic [63:0]   quo;
	logic [8:0]    len_clip;
	logic signed [32:0] xdiff;
	logic [32:0]   mdist;
	logic signed [35:0] sum;

	// effective length, clamped to 2..TABLE_DEPTH
	always_comb begin
		len_clip = table_length;
		if (len_clip < 9'd2) len_clip = 9'd2;
		if (int'(len_clip) > TABLE_DEPTH)
			len_clip = 9'(TABLE_DEPTH);
	end

	assign xdiff = 33'(signed'(xq_q)) - 33'(signed'(xrd_q));
	assign mdist = xdiff[32] ? 33'(-xdiff) : 33'(xdiff);
	assign sum   = neg_q ? (36'(signed'(yl_q)) - signed'({2'b0, quo[33:0]}))
	                     : (36'(signed'(yl_q)) + signed'({2'b0, quo[33:0]}));

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_OUT);
	assign div_start  = (state_q == S_DIV);

	// read address per state
	always_comb begin
		unique case (state_q)
			S_SCAN:  raddr = idx_q[AW-1:0];
			S_NEAR:  raddr = near_q;
			S_RDLO:  raddr = hi_q - AW'(1);
			default: raddr = hi_q;
		endcase
	end

	// table memories, registered read
	always_ff @(posedge clk) begin
		if (item_valid && item_ready && item.func == nbli_pkg::FUNC_LOAD &&
		    {1'b0, item.entry_index} < 9'(TABLE_DEPTH < 512 ? TABLE_DEPTH : 511)) begin
			x_mem[AW'(item.entry_index)] <= item.x_value;
			y_mem[AW'(item.entry_index)] <= item.y_value;
		end
		xrd_q <= x_mem[raddr];
		yrd_q <= y_mem[raddr];
	end

	nbli_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod_q), .divisor(mdx_q), .done(div_done), .quotient(quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; n_q <= '0; idx_q <= '0; near_q <= '0; hi_q <= '0;
			rd_v_q <= 1'b0; rd_i_q <= '0; first_q <= 1'b0; best_q <= '0;
			xq_q <= '0; xl_q <= '0; yl_q <= '0; dx_q <= '0; dy_q <= '0; dq_q <= '0;
			mdy_q <= '0; mdq_q <= '0; mdx_q <= '0; prod_q <= '0; neg_q <= 1'b0;
			res_value <= '0; res_status <= nbli_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && item.func == nbli_pkg::FUNC_QUERY) begin
						xq_q    <= item.x_value;
						n_q     <= CW'(len_clip);
						idx_q   <= '0;
						rd_v_q  <= 1'b0;
						first_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one address issued, one distance compared per cycle
					if (rd_v_q && (first_q || mdist < best_q)) begin
						best_q <= mdist; near_q <= rd_i_q;
					end
					if (rd_v_q) first_q <= 1'b0;
					rd_i_q <= idx_q[AW-1:0];
					if (idx_q < n_q) begin
						rd_v_q <= 1'b1;
						idx_q  <= idx_q + CW'(1);
					end else begin
						rd_v_q <= 1'b0;
						if (!rd_v_q) state_q <= S_NEAR;
					end
				end
				S_NEAR: state_q <= S_LAST;
				S_LAST: begin
					// xrd/yrd hold the nearest entry
					if (xrd_q == xq_q) begin
						res_value <= yrd_q; res_status <= nbli_pkg::ST_OK;
						state_q <= S_OUT;
					end else begin
						if ($signed(xq_q) < $signed(xrd_q))
							hi_q <= (near_q == '0) ? AW'(1) : near_q;
						else
							hi_q <= ({1'b0, near_q} == n_q - CW'(1)) ? near_q : near_q + AW'(1);
						state_q <= S_RDLO;
					end
				end
				S_RDLO: state_q <= S_RDHI;
				S_RDHI: begin
					xl_q <= xrd_q; yl_q <= yrd_q;
					dq_q <= 33'(signed'(xq_q)) - 33'(signed'(xrd_q));
					state_q <= S_CALC;
				end
				S_CALC: begin
					dx_q <= 33'(signed'(xrd_q)) - 33'(signed'(xl_q));
					dy_q <= 33'(signed'(yrd_q)) - 33'(signed'(yl_q));
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (dx_q == '0) begin
						res_value <= '0; res_status <= nbli_pkg::ST_SPAN;
						state_q <= S_OUT;
					end else begin
						mdx_q <= dx_q[32] ? 33'(-dx_q) : dx_q;
						mdy_q <= dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
						mdq_q <= dq_q[32] ? 32'(-dq_q) : dq_q[31:0];
						neg_q <= (dy_q != '0) && (dq_q != '0) &&
						         ((dy_q[32] ^ dq_q[32]) ^ dx_q[32]);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= 64'(mdy_q) * 64'(mdq_q);
					state_q <= S_DIV;
				end
				// single-cycle start pulse to the divider
				S_DIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) begin
						if (quo[63:34] != '0) begin
							res_value  <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
							res_status <= nbli_pkg::ST_SAT;
						end else if (sum > 36'sh0_7FFF_FFFF) begin
							res_value <= 32'h7FFF_FFFF; res_status <= nbli_pkg::ST_SAT;
						end else if (sum < -36'sh0_8000_0000) begin
							res_value <= 32'h8000_0000; res_status <= nbli_pkg::ST_SAT;
						end else begin
							res_value <= sum[31:0]; res_status <= nbli_pkg::ST_OK;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hdl/nearest_bracket_linear_interp.sv
// Nearest-bracket linear interpolator over a 2..TABLE_DEPTH entry Q16.16 table.
// Loads are taken while the engine is idle; a query holds it through a nearest scan at
// one read per cycle, a bracket fetch and a bit-serial divide, which an exact hit or a
// zero span skips. Output register plus a two-beat input queue decouple.
// Reset (arst_n, asynchronous) clears control and sets table_length to 2; table
// contents are undefined until loaded.
`default_nettype none
module nearest_bracket_linear_interp #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // entry_index[7:0], x_value[39:8], y_value[71:40]
	input  wire logic        s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // result_value[31:0], status[33:32], zero fill
);
	logic [8:0] len_q;
	nbli_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;
	logic [31:0] rv;
	logic [1:0]  rs;

	assign pready = 1'b1;
	assign prdata = (paddr == nbli_pkg::REG_TABLE_LENGTH) ? {23'b0, len_q} : 32'b0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_q <= 9'd2;
		else if (psel && penable && pwrite && paddr == nbli_pkg::REG_TABLE_LENGTH)
			len_q <= pwdata[8:0];
	end

	assign in_item = '{func: s_tuser, entry_index: s_tdata[7:0],
	                   x_value: s_tdata[39:8], y_value: s_tdata[71:40]};

	nbli_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_item(in_item), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	nbli_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .table_length(len_q),
		.item_valid(q_valid), .item_ready(q_ready), .item(q_item),
		.res_valid(m_tvalid), .res_ready(m_tready), .res_value(rv), .res_status(rs)
	);

	assign m_tdata = {6'b0, rs, rv};

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == nbli_pkg::ST_SAT |->
		(m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000))
		else $error("saturated result not at a bound");
	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == nbli_pkg::ST_SPAN |-> m_tdata[31:0] == 32'b0)
		else $error("zero-span result not zero");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == nbli_pkg::REG_TABLE_LENGTH |=>
		len_q == $past(pwdata[8:0]))
		else $error("table_length write lost");
endmodule
`default_nettype wire
